// ===== sv/bmp_pkg.sv =====
// shared types and constants for the bmp stream decoder
// no dependencies
package bmp_pkg;

  localparam int unsigned SIDE_W      = 13;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned LIMIT_W     = 26;
  localparam int unsigned MAX_SIDE_DEF = 4096;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 88;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] HDR_END       = 32'd54;
  localparam logic [31:0] PAL_END       = 32'd1078;
  localparam logic [31:0] INFO_MIN      = 32'd40;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 26'd33554432 - 26'd1 + 26'd1;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_PALETTE = 3'd1,
    KIND_PIXEL   = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNCATED  = 3'd1,
    ST_BAD_SIG    = 3'd2,
    ST_UNSUPPORT  = 3'd3,
    ST_BAD_SIZE   = 3'd4,
    ST_BAD_OFFSET = 3'd5
  } status_e;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [7:0]         pal_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [SIDE_W-1:0]  image_width;
    logic [SIDE_W-1:0]  image_height;
    logic               deep_color;
    logic               last_of_file;
  } result_t;

endpackage

// ===== sv/bmp_stream_decoder_unit.sv =====
// bmp stream decoder top level: header parse, palette and pixel emission
// plus a four-entry result queue; depends on bmp_pkg
//
// channel   | dir | tdata                        | tuser | tlast
// s_axis    | in  | data_byte                    | -     | last_byte
// m_axis    | out | status..deep_color (see port) | kind  | last_of_file
// cfg       | in  | max_output_bytes, no handshake beyond cfg_we_i
//
// one byte is taken per cycle while s_axis_tready_o is high; every request is
// parsed in the cycle it is accepted and its results (at most two, two only
// on the last byte) land in the result queue at the next edge. the queue
// holds four entries and s_axis_tready_o is high while at least two are
// free, so a stalled sink backs up into the input once three results are
// queued. reset clears all parse state and sets the size limit to 33554432;
// no clearing pass is needed.
module bmp_stream_decoder_unit
  import bmp_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic                   s_axis_tlast_i,   // last_byte
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [2:0] status, [14:3] row, [26:15] column, [34:27] pal_index,
  // [42:35] red, [50:43] green, [58:51] blue, [71:59] image_width,
  // [84:72] image_height, [85] deep_color, [87:86] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [2:0]             m_axis_tuser_o,   // kind
  output logic                   m_axis_tlast_o,   // last_of_file
  input  logic                   cfg_we_i,
  input  logic [LIMIT_W-1:0]     cfg_wdata_i       // max_output_bytes
);

  // parse state
  logic [31:0]        pos_q, pos_d;
  logic [31:0]        pix_off_q, pix_off_d;
  logic [31:0]        info_size_q, info_size_d;
  logic [31:0]        raw_w_q, raw_w_d;
  logic [31:0]        raw_h_q, raw_h_d;
  logic [15:0]        planes_q, planes_d;
  logic [15:0]        depth_q, depth_d;
  logic [31:0]        comp_q, comp_d;
  logic [15:0]        sig_q, sig_d;
  logic [2:0]         err_q, err_d;
  logic               done_q, done_d;
  logic [COORD_W-1:0] row_q, row_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [1:0]         bip_q, bip_d;
  logic [1:0]         pad_q, pad_d;
  logic [15:0]        held_q, held_d;
  logic [LIMIT_W-1:0] limit_q;

  // result queue
  result_t    fifo_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  logic       in_fire, out_fire;
  logic [7:0] b;
  logic       deep;
  logic [31:0] abs_h;
  logic [SIDE_W-1:0] w13, h13;
  logic [2*SIDE_W:0] area2;
  logic [2:0]  chk;
  logic [9:0]  rel;
  logic [COORD_W-1:0] dest;
  logic [1:0]  wmod, pad_new;
  logic        a_vld;
  result_t     res_a, res_b, slot0, slot1;
  logic [2:0]  err_fin;
  logic [1:0]  n_push;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign b        = s_axis_tdata_i;
  assign deep     = (depth_q == 16'd24);
  assign abs_h    = raw_h_q[31] ? (~raw_h_q + 32'd1) : raw_h_q;
  assign w13      = raw_w_q[SIDE_W-1:0];
  assign h13      = abs_h[SIDE_W-1:0];
  // only meaningful once both sides passed the MAX_SIDE check
  assign area2    = {(2*SIDE_W)'(w13) * (2*SIDE_W)'(h13), 1'b0};
  assign rel      = 10'(pos_q[10:0] - 11'd54);
  assign dest     = raw_h_q[31] ? row_q : COORD_W'(h13 - 13'd1 - {1'b0, row_q});
  assign wmod     = deep ? 2'(w13[1:0] * 2'd3) : w13[1:0];
  assign pad_new  = 2'(2'd0 - wmod);

  // header check in priority order
  always_comb begin
    chk = ST_OK;
    if (sig_q != BMP_SIGNATURE) chk = ST_BAD_SIG;
    else if (info_size_q < INFO_MIN || planes_q != 16'd1 || comp_q != 32'd0) chk = ST_UNSUPPORT;
    else if (raw_w_q == 32'd0 || raw_w_q[31]) chk = ST_BAD_SIZE;
    else if (depth_q != 16'd8 && depth_q != 16'd24) chk = ST_UNSUPPORT;
    else if (abs_h == 32'd0 || raw_w_q > 32'(MAX_SIDE) || abs_h > 32'(MAX_SIDE))
      chk = ST_BAD_SIZE;
    else if (area2 > {1'b0, limit_q}) chk = ST_BAD_SIZE;
    else if (pix_off_q < HDR_END) chk = ST_BAD_OFFSET;
    else if (!deep && pix_off_q < PAL_END) chk = ST_BAD_OFFSET;
  end

  // next state and results for the byte at the input
  always_comb begin
    pos_d = pos_q; pix_off_d = pix_off_q; info_size_d = info_size_q;
    raw_w_d = raw_w_q; raw_h_d = raw_h_q; planes_d = planes_q;
    depth_d = depth_q; comp_d = comp_q; sig_d = sig_q; err_d = err_q;
    done_d = done_q; row_d = row_q; col_d = col_q; bip_d = bip_q;
    pad_d = pad_q; held_d = held_q;
    a_vld = 1'b0;
    res_a = '0;
    res_b = '0;
    err_fin = err_q;

    if (pos_q < HDR_END) begin
      // little-endian header fields, each byte lands once
      case (pos_q[5:0])
        6'd0:  sig_d[7:0]         = b;
        6'd1:  sig_d[15:8]        = b;
        6'd10: pix_off_d[7:0]     = b;
        6'd11: pix_off_d[15:8]    = b;
        6'd12: pix_off_d[23:16]   = b;
        6'd13: pix_off_d[31:24]   = b;
        6'd14: info_size_d[7:0]   = b;
        6'd15: info_size_d[15:8]  = b;
        6'd16: info_size_d[23:16] = b;
        6'd17: info_size_d[31:24] = b;
        6'd18: raw_w_d[7:0]       = b;
        6'd19: raw_w_d[15:8]      = b;
        6'd20: raw_w_d[23:16]     = b;
        6'd21: raw_w_d[31:24]     = b;
        6'd22: raw_h_d[7:0]       = b;
        6'd23: raw_h_d[15:8]      = b;
        6'd24: raw_h_d[23:16]     = b;
        6'd25: raw_h_d[31:24]     = b;
        6'd26: planes_d[7:0]      = b;
        6'd27: planes_d[15:8]     = b;
        6'd28: depth_d[7:0]       = b;
        6'd29: depth_d[15:8]      = b;
        6'd30: comp_d[7:0]        = b;
        6'd31: comp_d[15:8]       = b;
        6'd32: comp_d[23:16]      = b;
        6'd33: comp_d[31:24]      = b;
        default: ;
      endcase
      // byte 53 holds no field, so the check sees the full header
      if (pos_q[5:0] == 6'd53) begin
        err_d = chk;
        if (chk == ST_OK) begin
          a_vld = 1'b1;
          res_a.kind = KIND_HEADER;
          res_a.image_width = w13;
          res_a.image_height = h13;
          res_a.deep_color = deep;
        end
      end
    end else if (err_q == ST_OK && !done_q) begin
      if (pos_q < pix_off_q) begin
        if (!deep && pos_q < PAL_END) begin
          // palette entries are stored b, g, r, reserved
          case (rel[1:0])
            2'd0: held_d = {8'd0, b};
            2'd1: held_d = {b, held_q[7:0]};
            2'd2: begin
              a_vld = 1'b1;
              res_a.kind = KIND_PALETTE;
              res_a.pal_index = rel[9:2];
              res_a.red = b;
              res_a.green = held_q[15:8];
              res_a.blue = held_q[7:0];
            end
            default: ;
          endcase
        end
      end else if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
        if (pad_q == 2'd1) begin
          if ({1'b0, row_q} + 13'd1 >= h13) done_d = 1'b1;
          else row_d = row_q + 1'b1;
        end
      end else begin
        logic pix_end;
        pix_end = 1'b0;
        if (!deep) begin
          a_vld = 1'b1;
          res_a.kind = KIND_PIXEL;
          res_a.row = dest;
          res_a.column = col_q;
          res_a.pal_index = b;
          pix_end = 1'b1;
        end else begin
          case (bip_q)
            2'd0: begin held_d = {8'd0, b}; bip_d = 2'd1; end
            2'd1: begin held_d = {b, held_q[7:0]}; bip_d = 2'd2; end
            default: begin
              a_vld = 1'b1;
              res_a.kind = KIND_PIXEL;
              res_a.row = dest;
              res_a.column = col_q;
              res_a.red = b;
              res_a.green = held_q[15:8];
              res_a.blue = held_q[7:0];
              bip_d = 2'd0;
              pix_end = 1'b1;
            end
          endcase
        end
        if (pix_end) begin
          if ({1'b0, col_q} + 13'd1 >= w13) begin
            col_d = '0;
            pad_d = pad_new;
            if (pad_new == 2'd0) begin
              if ({1'b0, row_q} + 13'd1 >= h13) done_d = 1'b1;
              else row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
    end

    if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;

    if (s_axis_tlast_i) begin
      err_fin = (err_d == ST_OK && !done_d) ? ST_TRUNCATED : err_d;
      res_b.last_of_file = 1'b1;
      if (err_fin != ST_OK) begin
        res_b.kind = KIND_ERROR;
        res_b.status = status_e'(err_fin);
      end else begin
        res_b.kind = KIND_DONE;
      end
      // next byte starts a fresh file
      pos_d = '0; pix_off_d = '0; info_size_d = '0; raw_w_d = '0; raw_h_d = '0;
      planes_d = '0; depth_d = '0; comp_d = '0; sig_d = '0; err_d = '0;
      done_d = 1'b0; row_d = '0; col_d = '0; bip_d = '0; pad_d = '0; held_d = '0;
    end
  end

  // compact the one or two results into queue slots
  always_comb begin
    slot0  = a_vld ? res_a : res_b;
    slot1  = res_b;
    n_push = 2'(a_vld) + 2'(s_axis_tlast_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; pix_off_q <= '0; info_size_q <= '0; raw_w_q <= '0;
      raw_h_q <= '0; planes_q <= '0; depth_q <= '0; comp_q <= '0;
      sig_q <= '0; err_q <= '0; done_q <= 1'b0; row_q <= '0; col_q <= '0;
      bip_q <= '0; pad_q <= '0; held_q <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (in_fire) begin
        pos_q <= pos_d; pix_off_q <= pix_off_d; info_size_q <= info_size_d;
        raw_w_q <= raw_w_d; raw_h_q <= raw_h_d; planes_q <= planes_d;
        depth_q <= depth_d; comp_q <= comp_d; sig_q <= sig_d; err_q <= err_d;
        done_q <= done_d; row_q <= row_d; col_q <= col_d; bip_q <= bip_d;
        pad_q <= pad_d; held_q <= held_d;
      end
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) wr_ptr_q <= wr_ptr_q + n_push;
      if (out_fire) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + (in_fire ? 3'(n_push) : 3'd0) - 3'(out_fire);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && n_push != 2'd0) fifo_q[wr_ptr_q] <= slot0;
    if (in_fire && n_push == 2'd2) fifo_q[wr_ptr_q + 2'd1] <= slot1;
  end

  result_t head;
  assign head = fifo_q[rd_ptr_q];

  assign s_axis_tready_o = (count_q <= 3'd2);
  assign m_axis_tvalid_o = (count_q != 3'd0);
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last_of_file;
  assign m_axis_tdata_o  = {2'b00, head.deep_color, head.image_height, head.image_width,
                            head.blue, head.green, head.red, head.pal_index,
                            head.column, head.row, head.status};

endmodule

// ===== sv/bmp_stream_decoder_checker.sv =====
// port-level checks for the bmp stream decoder, bound to the top level
// depends on bmp_pkg
module bmp_stream_decoder_checker
  import bmp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [2:0]             m_axis_tuser_o,
  input logic                   m_axis_tlast_o
);

  // end of file only on done or error
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      (m_axis_tuser_o == KIND_DONE || m_axis_tuser_o == KIND_ERROR))
    else $error("tlast on non-final kind");

  // status is nonzero only on error results
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != KIND_ERROR |-> m_axis_tdata_o[2:0] == 3'd0)
    else $error("status on non-error result");

  // error results always end the file
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_ERROR |-> m_axis_tlast_o)
    else $error("error without tlast");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind bmp_stream_decoder_unit bmp_stream_decoder_checker u_checker (.*);
